// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Widths of the normalized datapath and the control word that travels with
// each item through the cell chains.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// four quaternion components: x, y, z, w
	localparam int LANES      = 4;
	// normalized magnitude width, largest magnitude lies in [2^30, 2^31)
	localparam int MAG_W      = 31;
	// sum of four squared magnitudes
	localparam int SUM_W      = 64;
	// integer root of the sum
	localparam int ROOT_W     = 32;
	// one root cell per result bit
	localparam int ROOT_STEPS = 32;

	// control word handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             degen;
		logic [LANES-1:0] neg;
	} ctl_t;

endpackage

// ===== rtl/rmq_if.sv =====
// ----------------------------------------------------------------------------
// rmq_if: item channels
// Matrix channel into the block and quaternion channel out of it, both with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_mat_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] m00, m01, m02;
	logic signed [DATA_WIDTH-1:0] m10, m11, m12;
	logic signed [DATA_WIDTH-1:0] m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw;
	logic                         degenerate;

	modport source (output valid, qx, qy, qz, qw, degenerate, input ready);
	modport sink (input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

// ===== rtl/rmq_norm_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_norm_cell: one step of the normalizing shifter
// Shifts all four magnitudes left by SHIFT when the top SHIFT bits of the
// running maximum are clear.
// ----------------------------------------------------------------------------
module rmq_norm_cell import rmq_pkg::*; #(
	parameter int W     = 31,
	parameter int SHIFT = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  ctl_t                      ctl_in,
	input  logic [LANES-1:0][W-1:0]   mag_in,
	input  logic [W-1:0]              max_in,
	output ctl_t                      ctl_q,
	output logic [LANES-1:0][W-1:0]   mag_q,
	output logic [W-1:0]              max_q
);

	logic hit;

	// leading bits all zero: take the shift
	assign hit = (max_in[W-1 -: SHIFT] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < LANES; c++) begin
				mag_q[c] <= hit ? (mag_in[c] << SHIFT) : mag_in[c];
			end
			max_q <= hit ? (max_in << SHIFT) : max_in;
		end
	end

endmodule

// ===== rtl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one iteration of the integer square root
// Restoring digit-by-digit root, two radicand bits per cell; the magnitudes
// ride along unchanged.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ctl_t                          ctl_in,
	input  logic [SUM_W-1:0]              n_in,
	input  logic [SUM_W-1:0]              r_in,
	input  logic [LANES-1:0][MAG_W-1:0]   mag_in,
	output ctl_t                          ctl_q,
	output logic [SUM_W-1:0]              n_q,
	output logic [SUM_W-1:0]              r_q,
	output logic [LANES-1:0][MAG_W-1:0]   mag_q
);

	localparam logic [SUM_W-1:0] BIT =
		{{(SUM_W-1){1'b0}}, 1'b1} << (2 * (ROOT_STEPS - 1 - STEP));

	logic [SUM_W:0] trial;
	logic           fit;

	// try to take r + b out of the remainder
	assign trial = {1'b0, r_in} + {1'b0, BIT};
	assign fit   = ({1'b0, n_in} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q   <= fit ? (n_in - trial[SUM_W-1:0]) : n_in;
			r_q   <= fit ? ((r_in >> 1) + BIT) : (r_in >> 1);
			mag_q <= mag_in;
		end
	end

endmodule

// ===== rtl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit of the restoring divider
// Four lanes share one divisor; each lane shifts in a numerator bit at the
// bottom of its remainder and a quotient bit at the bottom of x.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
	parameter int QB = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  ctl_t                           ctl_in,
	input  logic [ROOT_W-1:0]              l_in,
	input  logic [LANES-1:0][ROOT_W-1:0]   rem_in,
	input  logic [LANES-1:0][QB-1:0]       x_in,
	output ctl_t                           ctl_q,
	output logic [ROOT_W-1:0]              l_q,
	output logic [LANES-1:0][ROOT_W-1:0]   rem_q,
	output logic [LANES-1:0][QB-1:0]       x_q
);

	logic [LANES-1:0][ROOT_W:0]   cand;
	logic [LANES-1:0]             fit;
	logic [LANES-1:0][ROOT_W-1:0] rem_nx;
	logic [LANES-1:0][QB-1:0]     x_nx;

	// compare and subtract per lane
	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			cand[c]   = {rem_in[c], x_in[c][QB-1]};
			fit[c]    = (cand[c] >= {1'b0, l_in});
			rem_nx[c] = fit[c] ? ROOT_W'(cand[c] - {1'b0, l_in}) : cand[c][ROOT_W-1:0];
			x_nx[c]   = {x_in[c][QB-2:0], fit[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_q   <= l_in;
			rem_q <= rem_nx;
			x_q   <= x_nx;
		end
	end

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: rotation matrix to unit quaternion
// Shoemake's method on fixed-point data, followed by normalization.
// ----------------------------------------------------------------------------
// Usage:
// - mat carries one 3x3 rotation matrix per item, nine signed elements with
//   FRAC_BITS fraction bits. quat returns one item per matrix: qx, qy, qz,
//   qw in the same format and the degenerate flag (identity returned).
// - One matrix is taken per cycle while mat.ready is high. The pipeline
//   holds the 32-cell root chain and the FRAC_BITS+2 cell divider.
// - Results leave through an output register. While it holds a result the
//   pipeline keeps moving until an item reaches the last cell; only then
//   does mat.ready drop, and it rises again once quat.ready takes the item.
// - Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	rmq_mat_if.sink    mat,
	rmq_quat_if.source quat
);

	localparam int VW      = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
	localparam int NW      = (VW > MAG_W) ? VW : MAG_W;
	localparam int NSTG    = $clog2(NW);
	localparam int QB      = FRAC_BITS + 2;
	localparam int NUM_W   = MAG_W + FRAC_BITS + 1;
	localparam int PW      = ((QB > DATA_WIDTH) ? QB : DATA_WIDTH) + 1;
	localparam logic [VW-1:0] ONE_U = VW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] POS_LIM = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
	localparam logic [PW-1:0] NEG_LIM = PW'(1) << (DATA_WIDTH - 1);
	localparam logic [DATA_WIDTH-1:0] ID_W = (FRAC_BITS >= DATA_WIDTH - 1) ?
		DATA_WIDTH'(POS_LIM) : (DATA_WIDTH'(1) << FRAC_BITS);

	typedef enum logic [1:0] {AX_X = 2'd0, AX_Y = 2'd1, AX_Z = 2'd2} axis_t;

	logic en;
	logic ovalid_q;

	// ---------------- stage 1: input register ----------------
	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] m_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0][0] <= mat.m00; m_s1[0][1] <= mat.m01; m_s1[0][2] <= mat.m02;
			m_s1[1][0] <= mat.m10; m_s1[1][1] <= mat.m11; m_s1[1][2] <= mat.m12;
			m_s1[2][0] <= mat.m20; m_s1[2][1] <= mat.m21; m_s1[2][2] <= mat.m22;
		end
	end

	// ---------------- stage 2: branch and unnormalized vector ----------------
	logic signed [VW-1:0] e [3][3];
	logic signed [VW-1:0] trace, diag_i, arg;
	logic signed [VW-1:0] vec [LANES];
	logic signed [VW-1:0] vec_s2 [LANES];
	logic                 bad;
	axis_t                ax;
	ctl_t                 ctl_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				e[r][c] = VW'(m_s1[r][c]);
			end
		end
	end

	always_comb begin
		trace = e[0][0] + e[1][1] + e[2][2];
		// largest diagonal element, ties keep the lower axis
		ax = AX_X;
		if (e[1][1] > e[0][0]) ax = AX_Y;
		diag_i = (ax == AX_Y) ? e[1][1] : e[0][0];
		if (e[2][2] > diag_i) ax = AX_Z;
		arg = '0;
		bad = 1'b0;
		if (trace > 0) begin
			vec[0] = e[2][1] - e[1][2];
			vec[1] = e[0][2] - e[2][0];
			vec[2] = e[1][0] - e[0][1];
			vec[3] = trace + $signed(ONE_U);
		end else begin
			unique case (ax)
				AX_Y: begin
					arg    = e[1][1] - e[2][2] - e[0][0] + $signed(ONE_U);
					vec[1] = arg;
					vec[2] = e[2][1] + e[1][2];
					vec[0] = e[0][1] + e[1][0];
					vec[3] = e[0][2] - e[2][0];
				end
				AX_Z: begin
					arg    = e[2][2] - e[0][0] - e[1][1] + $signed(ONE_U);
					vec[2] = arg;
					vec[0] = e[0][2] + e[2][0];
					vec[1] = e[1][2] + e[2][1];
					vec[3] = e[1][0] - e[0][1];
				end
				default: begin
					arg    = e[0][0] - e[1][1] - e[2][2] + $signed(ONE_U);
					vec[0] = arg;
					vec[1] = e[1][0] + e[0][1];
					vec[2] = e[2][0] + e[0][2];
					vec[3] = e[2][1] - e[1][2];
				end
			endcase
			// a root argument of zero or less marks the item degenerate
			bad = (arg <= 0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.degen <= bad;
			ctl_s2.neg   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2 <= vec;
		end
	end

	// ---------------- stage 3: sign and magnitude ----------------
	logic [LANES-1:0][VW-1:0] magv;
	logic [LANES-1:0]         negv;
	logic [VW-1:0]            mx;
	ctl_t                     ctl_s3;
	logic [LANES-1:0][NW-1:0] mag_s3;
	logic [NW-1:0]            max_s3;

	always_comb begin
		mx = '0;
		for (int c = 0; c < LANES; c++) begin
			negv[c] = vec_s2[c][VW-1];
			magv[c] = negv[c] ? VW'(-vec_s2[c]) : VW'(vec_s2[c]);
			if (magv[c] > mx) mx = magv[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.degen <= ctl_s2.degen || (mx == '0);
			ctl_s3.neg   <= negv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < LANES; c++) begin
				mag_s3[c] <= NW'(magv[c]);
			end
			max_s3 <= NW'(mx);
		end
	end

	// ---------------- normalizing shifter chain ----------------
	ctl_t                     ctl_n [NSTG+1];
	logic [LANES-1:0][NW-1:0] mag_n [NSTG+1];
	logic [NW-1:0]            max_n [NSTG+1];

	assign ctl_n[0] = ctl_s3;
	assign mag_n[0] = mag_s3;
	assign max_n[0] = max_s3;

	for (genvar k = 0; k < NSTG; k++) begin : g_norm
		rmq_norm_cell #(.W(NW), .SHIFT(1 << (NSTG - 1 - k))) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_n[k]),
			.mag_in (mag_n[k]),
			.max_in (max_n[k]),
			.ctl_q  (ctl_n[k+1]),
			.mag_q  (mag_n[k+1]),
			.max_q  (max_n[k+1])
		);
	end

	// ---------------- squares and their sum ----------------
	logic [LANES-1:0][MAG_W-1:0]   a;
	logic [LANES-1:0][MAG_W-1:0]   a_s4, a_s5, a_s6;
	logic [LANES-1:0][2*MAG_W-1:0] sq_s4;
	logic [1:0][2*MAG_W:0]         ps_s5;
	logic [SUM_W-1:0]              sum_s6;
	ctl_t                          ctl_s4, ctl_s5, ctl_s6;

	// top bits of the normalized word: exact left shift or truncated right
	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			a[c] = mag_n[NSTG][c][NW-1 -: MAG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_n[NSTG];
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < LANES; c++) begin
				sq_s4[c] <= (2*MAG_W)'(a[c]) * (2*MAG_W)'(a[c]);
			end
			ps_s5[0] <= {1'b0, sq_s4[0]} + {1'b0, sq_s4[1]};
			ps_s5[1] <= {1'b0, sq_s4[2]} + {1'b0, sq_s4[3]};
			sum_s6   <= {1'b0, ps_s5[0]} + {1'b0, ps_s5[1]};
			a_s4     <= a;
			a_s5     <= a_s4;
			a_s6     <= a_s5;
		end
	end

	// ---------------- square root chain ----------------
	ctl_t                        ctl_q [ROOT_STEPS+1];
	logic [SUM_W-1:0]            n_q   [ROOT_STEPS+1];
	logic [SUM_W-1:0]            r_q   [ROOT_STEPS+1];
	logic [LANES-1:0][MAG_W-1:0] mag_q [ROOT_STEPS+1];

	assign ctl_q[0] = ctl_s6;
	assign n_q[0]   = sum_s6;
	assign r_q[0]   = '0;
	assign mag_q[0] = a_s6;

	for (genvar t = 0; t < ROOT_STEPS; t++) begin : g_root
		rmq_sqrt_cell #(.STEP(t)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_q[t]),
			.n_in   (n_q[t]),
			.r_in   (r_q[t]),
			.mag_in (mag_q[t]),
			.ctl_q  (ctl_q[t+1]),
			.n_q    (n_q[t+1]),
			.r_q    (r_q[t+1]),
			.mag_q  (mag_q[t+1])
		);
	end

	// ---------------- stage 7: numerators with half-divisor rounding ----------------
	logic [ROOT_W-1:0]              len;
	logic [LANES-1:0][NUM_W-1:0]    num;
	logic [ROOT_W-1:0]              l_s7;
	logic [LANES-1:0][ROOT_W-1:0]   rem_s7;
	logic [LANES-1:0][QB-1:0]       x_s7;
	ctl_t                           ctl_s7;

	assign len = r_q[ROOT_STEPS][ROOT_W-1:0];

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			num[c] = (NUM_W'(mag_q[ROOT_STEPS][c]) << FRAC_BITS) + NUM_W'(len >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s7.valid <= ctl_q[ROOT_STEPS].valid;
			ctl_s7.degen <= ctl_q[ROOT_STEPS].degen || (len == '0);
			ctl_s7.neg   <= ctl_q[ROOT_STEPS].neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s7 <= len;
			for (int c = 0; c < LANES; c++) begin
				rem_s7[c] <= ROOT_W'(num[c][NUM_W-1:QB]);
				x_s7[c]   <= num[c][QB-1:0];
			end
		end
	end

	// ---------------- divider chain ----------------
	ctl_t                         ctl_d [QB+1];
	logic [ROOT_W-1:0]            l_d   [QB+1];
	logic [LANES-1:0][ROOT_W-1:0] rem_d [QB+1];
	logic [LANES-1:0][QB-1:0]     x_d   [QB+1];

	assign ctl_d[0] = ctl_s7;
	assign l_d[0]   = l_s7;
	assign rem_d[0] = rem_s7;
	assign x_d[0]   = x_s7;

	for (genvar d = 0; d < QB; d++) begin : g_div
		rmq_div_cell #(.QB(QB)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_d[d]),
			.l_in   (l_d[d]),
			.rem_in (rem_d[d]),
			.x_in   (x_d[d]),
			.ctl_q  (ctl_d[d+1]),
			.l_q    (l_d[d+1]),
			.rem_q  (rem_d[d+1]),
			.x_q    (x_d[d+1])
		);
	end

	// global advance: stop only when the last cell holds an item that cannot leave
	assign en        = !(ctl_d[QB].valid && ovalid_q && !quat.ready);
	assign mat.ready = en;

	// ---------------- output register with saturation ----------------
	logic [LANES-1:0][DATA_WIDTH-1:0] res;
	logic [PW-1:0]                    qe, mq;
	logic [LANES-1:0][DATA_WIDTH-1:0] q_q;
	logic                             degen_q;
	logic                             ld;

	always_comb begin
		qe = '0;
		mq = '0;
		for (int c = 0; c < LANES; c++) begin
			qe = PW'(x_d[QB][c]);
			if (ctl_d[QB].neg[c] && (qe != '0)) begin
				mq     = (qe > NEG_LIM) ? NEG_LIM : qe;
				res[c] = DATA_WIDTH'(PW'(0) - mq);
			end else begin
				mq     = (qe > POS_LIM) ? POS_LIM : qe;
				res[c] = DATA_WIDTH'(mq);
			end
		end
	end

	assign ld = ctl_d[QB].valid && (!ovalid_q || quat.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (!ovalid_q || quat.ready) begin
			ovalid_q <= ctl_d[QB].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			degen_q <= ctl_d[QB].degen;
			if (ctl_d[QB].degen) begin
				q_q <= {ID_W, {(3*DATA_WIDTH){1'b0}}};
			end else begin
				q_q <= {res[3], res[2], res[1], res[0]};
			end
		end
	end

	assign quat.valid      = ovalid_q;
	assign quat.qx         = q_q[0];
	assign quat.qy         = q_q[1];
	assign quat.qz         = q_q[2];
	assign quat.qw         = q_q[3];
	assign quat.degenerate = degen_q;

	// ---------------- assertions ----------------
	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.degenerate |->
			quat.qx == '0 && quat.qy == '0 && quat.qz == '0)
		else $error("degenerate result is not the identity");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!mat.ready |-> ovalid_q && !quat.ready && ctl_d[QB].valid)
		else $error("input stalled without a blocked result");

	a_norm_msb: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_n[NSTG].valid && !ctl_n[NSTG].degen |-> max_n[NSTG][NW-1])
		else $error("normalized maximum lacks its top bit");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q[ROOT_STEPS].valid && !ctl_q[ROOT_STEPS].degen |->
			r_q[ROOT_STEPS][ROOT_W-1:ROOT_W-2] != 2'b00)
		else $error("root of normalized sum out of range");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_d[QB].valid && !ctl_d[QB].degen |->
			x_d[QB][0] <= (QB'(1) << FRAC_BITS) && x_d[QB][3] <= (QB'(1) << FRAC_BITS))
		else $error("normalized component exceeds one");

endmodule

// ===== sim/tb_rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_unit: matrix to quaternion testbench
// Drives matrices through the mat channel and checks every quaternion on the
// quat channel against a bit-accurate predictor of the normalized result.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_unit;

	localparam int DW    = 16;
	localparam int FB    = 14;
	localparam int LAT   = 61;
	localparam int LIMIT = 400000;

	typedef logic signed [DW-1:0] elem_t;

	typedef struct packed {
		elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} matrix_t;

	typedef struct packed {
		elem_t qx, qy, qz, qw;
		logic  degenerate;
	} quat_t;

	logic clk;
	logic arst_n;

	rmq_mat_if  #(.DATA_WIDTH(DW)) mat ();
	rmq_quat_if #(.DATA_WIDTH(DW)) quat ();

	rotation_matrix_to_quaternion_unit #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.mat   (mat),
		.quat  (quat)
	);

	matrix_t pending_mats[$];
	quat_t   expected_quats[$];
	int      mismatches;
	int      cycles;
	int      hold_cycles;
	bit      hold_req;
	bit      hold_armed;

	always #1 clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// sign and saturate a magnitude to the output format
	function automatic elem_t to_elem(bit neg, logic [63:0] q);
		logic [63:0] maxpos;
		maxpos = (64'd1 << (DW - 1)) - 1;
		if (neg) begin
			if (q > maxpos + 1)
				q = maxpos + 1;
			return elem_t'(-q);
		end
		if (q > maxpos)
			q = maxpos;
		return elem_t'(q);
	endfunction

	function automatic quat_t identity_quat();
		quat_t r;
		r.qx = 0;
		r.qy = 0;
		r.qz = 0;
		r.qw = to_elem(1'b0, 64'd1 << FB);
		r.degenerate = 1'b1;
		return r;
	endfunction

	// Shoemake conversion on the exact integer vector, then normalization
	function automatic quat_t predict_quat(matrix_t mt);
		longint      m[3][3];
		longint      v[4];
		logic [63:0] mag[4];
		bit          neg[4];
		logic [63:0] maxm;
		logic [63:0] sum;
		logic [63:0] len;
		logic [63:0] q;
		longint      tr;
		longint      arg;
		int          i;
		int          j;
		int          k;
		quat_t       r;
		m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
		m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
		m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			v[0] = m[2][1] - m[1][2];
			v[1] = m[0][2] - m[2][0];
			v[2] = m[1][0] - m[0][1];
			v[3] = tr + (longint'(1) << FB);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			arg = m[i][i] - m[j][j] - m[k][k] + (longint'(1) << FB);
			if (arg <= 0)
				return identity_quat();
			v[i] = arg;
			v[j] = m[j][i] + m[i][j];
			v[k] = m[k][i] + m[i][k];
			v[3] = m[k][j] - m[j][k];
		end
		maxm = 0;
		for (int c = 0; c < 4; c++) begin
			neg[c] = v[c] < 0;
			mag[c] = neg[c] ? -v[c] : v[c];
			if (mag[c] > maxm)
				maxm = mag[c];
		end
		if (maxm == 0)
			return identity_quat();
		while (maxm >= (64'd1 << 31)) begin
			maxm = maxm >> 1;
			for (int c = 0; c < 4; c++)
				mag[c] = mag[c] >> 1;
		end
		while (maxm < (64'd1 << 30)) begin
			maxm = maxm << 1;
			for (int c = 0; c < 4; c++)
				mag[c] = mag[c] << 1;
		end
		sum = 0;
		for (int c = 0; c < 4; c++)
			sum = sum + mag[c] * mag[c];
		len = isqrt(sum);
		if (len == 0)
			return identity_quat();
		q = ((mag[0] << FB) + (len >> 1)) / len;
		r.qx = to_elem(neg[0] && q != 0, q);
		q = ((mag[1] << FB) + (len >> 1)) / len;
		r.qy = to_elem(neg[1] && q != 0, q);
		q = ((mag[2] << FB) + (len >> 1)) / len;
		r.qz = to_elem(neg[2] && q != 0, q);
		q = ((mag[3] << FB) + (len >> 1)) / len;
		r.qw = to_elem(neg[3] && q != 0, q);
		r.degenerate = 1'b0;
		return r;
	endfunction

	// gap length: mostly short, sometimes long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic elem_t rand_elem();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return elem_t'($urandom);
		if (p == 1)
			return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
		return elem_t'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// rotation from a random angle about one axis, plus small noise
	function automatic matrix_t rand_rotation();
		real     a;
		real     c;
		real     s;
		real     r[3][3];
		int      ax;
		int      b;
		int      d;
		matrix_t mt;
		a = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
		c = $cos(a);
		s = $sin(a);
		ax = $urandom_range(0, 2);
		b = (ax + 1) % 3;
		d = (b + 1) % 3;
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				r[x][y] = 0.0;
		r[ax][ax] = 1.0;
		r[b][b] = c;
		r[d][d] = c;
		r[b][d] = -s;
		r[d][b] = s;
		mt.m00 = elem_t'($rtoi(r[0][0] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m01 = elem_t'($rtoi(r[0][1] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m02 = elem_t'($rtoi(r[0][2] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m10 = elem_t'($rtoi(r[1][0] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m11 = elem_t'($rtoi(r[1][1] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m12 = elem_t'($rtoi(r[1][2] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m20 = elem_t'($rtoi(r[2][0] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m21 = elem_t'($rtoi(r[2][1] * 16384.0) + $urandom_range(0, 6) - 3);
		mt.m22 = elem_t'($rtoi(r[2][2] * 16384.0) + $urandom_range(0, 6) - 3);
		return mt;
	endfunction

	function automatic matrix_t diag(elem_t a, elem_t b, elem_t c, elem_t off);
		matrix_t mt;
		mt = '{default: off};
		mt.m00 = a;
		mt.m11 = b;
		mt.m22 = c;
		return mt;
	endfunction

	// matrix driver
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.valid <= 1'b0;
			drv_gap <= 0;
		end else if (!mat.valid || mat.ready) begin
			if (mat.valid && mat.ready)
				void'(pending_mats.pop_front());
			if (drv_gap > 0) begin
				mat.valid <= 1'b0;
				drv_gap <= drv_gap - 1;
			end else if ((mat.valid && mat.ready ? pending_mats.size() > 1 :
					pending_mats.size() > 0)) begin
				matrix_t nx;
				nx = (mat.valid && mat.ready) ? pending_mats[1] : pending_mats[0];
				{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
					mat.m20, mat.m21, mat.m22} <= nx;
				mat.valid <= 1'b1;
				drv_gap <= pick_gap();
			end else begin
				mat.valid <= 1'b0;
			end
		end
	end

	// predict on accept
	always @(posedge clk) begin
		if (arst_n && mat.valid && mat.ready)
			expected_quats.push_back(predict_quat({mat.m00, mat.m01, mat.m02,
				mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}));
	end

	// long receiver hold-off, counted once on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_armed <= 1'b1;
		end else if (hold_req && hold_armed) begin
			hold_cycles <= 300;
			hold_armed <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// receiver back-pressure; one long hold-off early in the random part
	int rcv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.ready <= 1'b0;
			rcv_gap <= 0;
		end else if (hold_cycles > 0) begin
			quat.ready <= 1'b0;
		end else if (rcv_gap > 0) begin
			quat.ready <= 1'b0;
			rcv_gap <= rcv_gap - 1;
		end else begin
			quat.ready <= 1'b1;
			rcv_gap <= pick_gap();
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && quat.valid && quat.ready) begin
			quat_t got;
			quat_t exp_q;
			got = '{quat.qx, quat.qy, quat.qz, quat.qw, quat.degenerate};
			if (expected_quats.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected quaternion %h", got);
			end else begin
				exp_q = expected_quats.pop_front();
				if (got !== exp_q) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display({"quat mismatch: exp x=%0d y=%0d z=%0d w=%0d d=%0b ",
							"got x=%0d y=%0d z=%0d w=%0d d=%0b"},
							exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.degenerate,
							got.qx, got.qy, got.qz, got.qw, got.degenerate);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		cycles = 0;
		hold_req = 1'b0;
		mat.m00 = 0; mat.m01 = 0; mat.m02 = 0;
		mat.m10 = 0; mat.m11 = 0; mat.m12 = 0;
		mat.m20 = 0; mat.m21 = 0; mat.m22 = 0;

		// directed: identity, trace branch, each diagonal pick, ties,
		// negative root, zero vector, field extremes
		pending_mats.push_back(diag(16384, 16384, 16384, 0));
		pending_mats.push_back(diag(-16384, -16384, 16384, 0));
		pending_mats.push_back(diag(16384, -16384, -16384, 0));
		pending_mats.push_back(diag(-16384, 16384, -16384, 0));
		pending_mats.push_back(diag(0, 0, 0, 0));
		pending_mats.push_back(diag(-100, -100, -100, 0));
		pending_mats.push_back(diag(-20000, -20000, -20000, 0));
		pending_mats.push_back(diag(-5000, -5000, 0, 77));
		pending_mats.push_back(diag(-16384, 0, 0, 0));
		pending_mats.push_back(diag(-16384, 0, 16384, 0));
		pending_mats.push_back(diag(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		pending_mats.push_back(diag(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		pending_mats.push_back(diag(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff));
		pending_mats.push_back(diag(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000));
		pending_mats.push_back(diag(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
		pending_mats.push_back(diag(1, 0, 0, 16'sh8000));
		pending_mats.push_back(diag(0, 0, 0, -1));
		pending_mats.push_back(diag(-1, -1, -1, 16'sh7fff));
		pending_mats.push_back(diag(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh5555));
		pending_mats.push_back(diag(16'sh8000, 16'sh8000, 16'sh7fff, 16'shaaaa));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_mats.size() == 0);

		// random part: mostly rotations, the rest arbitrary matrices
		for (int n = 0; n < 1530; n++) begin
			matrix_t mt;
			if (n == 200) begin
				@(posedge clk);
				hold_req <= 1'b1;
			end
			if ($urandom_range(0, 99) < 65) begin
				mt = rand_rotation();
			end else begin
				mt.m00 = rand_elem(); mt.m01 = rand_elem(); mt.m02 = rand_elem();
				mt.m10 = rand_elem(); mt.m11 = rand_elem(); mt.m12 = rand_elem();
				mt.m20 = rand_elem(); mt.m21 = rand_elem(); mt.m22 = rand_elem();
			end
			pending_mats.push_back(mt);
			if (pending_mats.size() > 64)
				wait (pending_mats.size() < 32);
		end

		wait (pending_mats.size() == 0);
		wait (expected_quats.size() == 0);
		repeat (2 * LAT) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("[rotation_matrix_to_quaternion_unit] OK");
		else
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
		$finish;
	end

endmodule
